// ===== rtl/page_table_pool_region_mapper_macros.svh =====
// Assertion helpers used by the mapper RTL.
`ifndef PAGE_TABLE_POOL_REGION_MAPPER_MACROS_SVH
`define PAGE_TABLE_POOL_REGION_MAPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTPRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTPRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ptprm_pkg.sv =====
package ptprm_pkg;

  localparam int DIR_SLOTS_DEF   = 1024;
  localparam int POOL_TABLES_DEF = 8;
  localparam int LOW_SLOTS_DEF   = 32;
  localparam int SLOT_SHIFT_DEF  = 22;

  localparam int ADDR_W      = 32;
  localparam int CNT_FIELD_W = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

endpackage

// ===== rtl/ptprm_ram.sv =====
module ptprm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/page_table_pool_region_mapper.sv =====
// Identity-mapping directory allocator.
// Input stream s_*: one transaction per region, tdata = {region_length, region_base}.
// Output stream m_*: one transaction per region with all_mapped, newly_allocated
// and pool_tables_used.
// Each region is walked one directory slot per cycle. The present bits sit in a
// synchronous RAM: a slot's address is issued in one cycle and its bit is checked,
// and set on allocation, in the next. Slots below LOW_SLOTS are skipped, slots at
// or beyond DIR_SLOTS fail, and a free slot takes the next pool table (its slot
// index is stored in the pool RAM) until the pool runs out.
// From input accept a region passes through ST_WALK, where its slots are issued
// and checked, and ST_FINISH, which loads the result into the output register.
// A new region is taken only once the previous walk has finished; a region that
// wraps past the top of the address space stops short of the top slot.
// After reset the present RAM is cleared, one entry per cycle, with s_tready low
// until the last entry is cleared. The pool count restarts at zero.
// The result sits in an output register; a stalled receiver holds it there, and
// the next region may be accepted and walked meanwhile, waiting at the end of
// its walk until the register frees up.
module page_table_pool_region_mapper #(
  parameter int DIR_SLOTS   = ptprm_pkg::DIR_SLOTS_DEF,
  parameter int POOL_TABLES = ptprm_pkg::POOL_TABLES_DEF,
  parameter int LOW_SLOTS   = ptprm_pkg::LOW_SLOTS_DEF,
  parameter int SLOT_SHIFT  = ptprm_pkg::SLOT_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] region_base, [63:32] region_length
  input  logic [ptprm_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] all_mapped, [4:1] newly_allocated, [8:5] pool_tables_used, [15:9] zero
  output logic [ptprm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  `include "page_table_pool_region_mapper_macros.svh"

  localparam int AW   = ptprm_pkg::ADDR_W;
  localparam int SW   = AW - SLOT_SHIFT;
  localparam int DA   = DIR_SLOTS > 1 ? $clog2(DIR_SLOTS) : 1;
  localparam int PA   = POOL_TABLES > 1 ? $clog2(POOL_TABLES) : 1;
  localparam int NFW  = $clog2(POOL_TABLES + 1);
  localparam int CW   = ptprm_pkg::CNT_FIELD_W;
  localparam logic [AW-1:0] SPAN_M1 = AW'((64'd1 << SLOT_SHIFT) - 64'd1);
  localparam int PAD_W = ptprm_pkg::OUT_TDATA_W - 1 - 2 * CW;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_FINISH} state_t;

  state_t          state;
  logic [DA-1:0]   clr_cnt;
  logic [SW-1:0]   cur;
  logic [SW-1:0]   end_slot;
  logic            s1_valid;
  logic            s1_check;
  logic            s1_fail;
  logic [DA-1:0]   s1_slot;
  logic            ok;
  logic [NFW-1:0]  taken;
  logic [NFW-1:0]  nf;

  logic [AW-1:0]   in_base;
  logic [AW-1:0]   in_len;
  logic [AW-1:0]   end_addr;
  logic [SW-1:0]   start_c;
  logic [SW-1:0]   end_c;
  logic [AW-1:0]   cur_ext;
  logic            issue;
  logic            is_low;
  logic            in_dir;
  logic [DA-1:0]   rd_addr;
  logic            present;
  logic            pool_free;
  logic            alloc;
  logic            fail1;
  logic            pres_we;
  logic [DA-1:0]   pres_waddr;
  logic [AW-1:0]   nf_ext;
  logic [AW-1:0]   taken_ext;
  logic [ptprm_pkg::OUT_TDATA_W-1:0] result;

  assign in_base  = s_tdata[AW-1:0];
  assign in_len   = s_tdata[2*AW-1:AW];
  assign end_addr = in_base + in_len + SPAN_M1;
  assign start_c  = in_base[AW-1:SLOT_SHIFT];

  always_comb begin
    if (in_len == '0) begin
      end_c = start_c;
    end else if (end_addr[AW-1:SLOT_SHIFT] == '0) begin
      end_c = '1;
    end else begin
      end_c = end_addr[AW-1:SLOT_SHIFT];
    end
  end

  assign cur_ext   = AW'(cur);
  assign issue     = (state == ST_WALK) && (cur < end_slot);
  assign is_low    = cur_ext < AW'(LOW_SLOTS);
  assign in_dir    = cur_ext < AW'(DIR_SLOTS);
  assign rd_addr   = cur_ext[DA-1:0];
  assign pool_free = nf < NFW'(POOL_TABLES);
  assign alloc     = s1_valid && s1_check && !present && pool_free;
  assign fail1     = s1_valid && (s1_fail || (s1_check && !present && !pool_free));

  assign pres_we    = (state == ST_CLEAR) || alloc;
  assign pres_waddr = (state == ST_CLEAR) ? clr_cnt : s1_slot;

  assign nf_ext    = AW'(nf);
  assign taken_ext = AW'(taken);
  assign result    = {PAD_W'(0), nf_ext[CW-1:0], taken_ext[CW-1:0], ok};

  assign s_tready = (state == ST_IDLE);

  ptprm_ram #(
    .WIDTH (1),
    .DEPTH (DIR_SLOTS)
  ) u_present (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (state != ST_CLEAR),
    .raddr (rd_addr),
    .rdata (present)
  );

  ptprm_ram #(
    .WIDTH (DA),
    .DEPTH (POOL_TABLES)
  ) u_pool (
    .clk   (clk),
    .we    (alloc),
    .waddr (nf_ext[PA-1:0]),
    .wdata (s1_slot),
    .raddr ('0),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      nf       <= '0;
      taken    <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      s1_valid <= issue;
      s1_check <= !is_low && in_dir;
      s1_fail  <= !is_low && !in_dir;
      s1_slot  <= rd_addr;
      if (alloc) begin
        nf    <= nf + 1'b1;
        taken <= taken + 1'b1;
      end
      if (fail1) begin
        ok <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == DA'(DIR_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cur      <= start_c;
            end_slot <= end_c;
            ok       <= 1'b1;
            taken    <= '0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (issue) begin
            cur <= cur + 1'b1;
          end else if (!s1_valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PTPRM_ASSERT_NOW(a_pool_bound, 1'b1, nf <= NFW'(POOL_TABLES), "pool count beyond pool size")
  `PTPRM_ASSERT_NOW(a_taken_bound, state != ST_CLEAR, taken <= nf, "request took more than pool gave")
  `PTPRM_ASSERT_NEXT(a_alloc_count, alloc, nf == $past(nf) + 1'b1, "allocation not counted")
  `PTPRM_ASSERT_NOW(a_no_alloc_idle, state == ST_IDLE || state == ST_FINISH, !s1_valid, "slot in flight outside walk")

endmodule

// ===== tb/tb_page_table_pool_region_mapper.sv =====
module tb_page_table_pool_region_mapper;

  localparam int DIR_SLOTS   = ptprm_pkg::DIR_SLOTS_DEF;
  localparam int POOL_TABLES = ptprm_pkg::POOL_TABLES_DEF;
  localparam int LOW_SLOTS   = ptprm_pkg::LOW_SLOTS_DEF;
  localparam int SLOT_SHIFT  = ptprm_pkg::SLOT_SHIFT_DEF;
  localparam int RANDOM_REGIONS = 560;

  typedef struct packed {
    logic [31:0] len_b;
    logic [31:0] base;
  } region_req_t;

  typedef struct packed {
    logic [3:0] pool_tables_used;
    logic [3:0] newly_allocated;
    logic       all_mapped;
  } region_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // [31:0] region_base, [63:32] region_length
  logic [ptprm_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [0] all_mapped, [4:1] newly_allocated, [8:5] pool_tables_used, [15:9] zero
  logic [ptprm_pkg::OUT_TDATA_W-1:0] m_tdata;

  region_req_t    pending_regions[$];
  region_result_t expected_results[$];
  int             total_regions;
  int             accepted_regions = 0;
  int             checked_results = 0;
  int             mismatches = 0;

  logic           slot_mapped [DIR_SLOTS];
  logic [9:0]     table_owner [POOL_TABLES];
  int             tables_taken;

  page_table_pool_region_mapper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic region_result_t map_region(input logic [31:0] base,
                                                input logic [31:0] len_b);
    logic [63:0]    span;
    logic [63:0]    align;
    logic [63:0]    start_a;
    logic [63:0]    end_a;
    logic [63:0]    addr;
    logic [63:0]    slot;
    int             taken;
    region_result_t res;
    span  = 64'd1 << SLOT_SHIFT;
    align = ~(span - 64'd1);
    taken = 0;
    res.all_mapped = 1'b1;
    if (len_b != 32'd0) begin
      start_a = {32'd0, base} & align;
      end_a = (({32'd0, base} + {32'd0, len_b} + span - 64'd1) & 64'hFFFF_FFFF) & align;
      // end wrapped to zero: stop short of the top slot
      if (end_a == 64'd0) end_a = 64'h1_0000_0000 - span;
      for (addr = start_a; addr < end_a; addr += span) begin
        slot = addr >> SLOT_SHIFT;
        if (slot < LOW_SLOTS) begin
        end else if (slot >= DIR_SLOTS) begin
          res.all_mapped = 1'b0;
        end else if (slot_mapped[slot]) begin
        end else if (tables_taken >= POOL_TABLES) begin
          res.all_mapped = 1'b0;
        end else begin
          table_owner[tables_taken] = slot[9:0];
          tables_taken++;
          taken++;
          slot_mapped[slot] = 1'b1;
        end
      end
    end
    res.newly_allocated  = taken[3:0];
    res.pool_tables_used = tables_taken[3:0];
    return res;
  endfunction

  function automatic int phase_of(input int n);
    return (n * 4) / (total_regions > 0 ? total_regions : 1);
  endfunction

  function automatic int send_idle_pct(input int n);
    case (phase_of(n))
      1: return 60;
      3: return 22;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input int n);
    case (phase_of(n))
      2: return 60;
      3: return 22;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             field, checked_results, got, want);
    mismatches++;
  endtask

  task automatic add_region(input logic [31:0] base, input logic [31:0] len_b);
    region_req_t r;
    r.base  = base;
    r.len_b = len_b;
    pending_regions.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_results.push_back(map_region(s_tdata[31:0], s_tdata[63:32]));
        accepted_regions++;
      end
      if (pending_regions.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct(accepted_regions)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_regions.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct(accepted_regions));
    end
  end

  // monitor
  always @(posedge clk) begin
    region_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[0] !== want.all_mapped)
          report_mismatch("all_mapped", int'(m_tdata[0]), int'(want.all_mapped));
        if (m_tdata[4:1] !== want.newly_allocated)
          report_mismatch("newly_allocated", int'(m_tdata[4:1]),
                          int'(want.newly_allocated));
        if (m_tdata[8:5] !== want.pool_tables_used)
          report_mismatch("pool_tables_used", int'(m_tdata[8:5]),
                          int'(want.pool_tables_used));
        if (m_tdata[15:9] !== 7'd0)
          report_mismatch("padding", int'(m_tdata[15:9]), 0);
      end
      checked_results++;
    end
  end

  initial begin
    logic [31:0] base;
    logic [31:0] len_b;
    int          kind;
    for (int i = 0; i < DIR_SLOTS; i++) slot_mapped[i] = (i < LOW_SLOTS);
    for (int i = 0; i < POOL_TABLES; i++) table_owner[i] = '0;
    tables_taken = 0;

    // directed
    add_region(32'h0000_0000, 32'h0000_0000);
    add_region(32'hFFFF_FFFF, 32'h0000_0000);
    add_region(32'h0000_0000, 32'h0000_0001);
    add_region(32'h07FF_FFFF, 32'h0000_0001);
    add_region(32'h0800_0000, 32'h0000_0001);
    add_region(32'h0800_0000, 32'h0000_0001);
    add_region(32'h07FF_FFFF, 32'h0000_0002);
    add_region(32'h0840_0000, 32'h0080_0000);
    add_region(32'hFFC0_0000, 32'h0040_0000);
    add_region(32'hF000_0000, 32'h2000_0000);
    add_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_region(32'hFF80_0000, 32'h0040_0000);
    add_region(32'hFF80_0000, 32'h0080_0000);
    add_region(32'h1000_0000, 32'h0100_0000);
    add_region(32'h2000_0000, 32'h0000_0001);
    add_region(32'h1FC0_0000, 32'h00C0_0000);
    add_region(32'h0800_0000, 32'h00C0_0000);
    add_region(32'h0000_0000, 32'h0800_0000);
    add_region(32'h0000_0000, 32'hFFFF_FFFF);
    add_region(32'h8000_0000, 32'h8000_0000);
    add_region(32'h1234_5678, 32'h0000_0000);

    for (int i = 0; i < RANDOM_REGIONS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // around the low span and the first allocated slots
        base  = ($urandom_range(0, 47) << SLOT_SHIFT) | ($urandom & 32'h003F_FFFF);
        len_b = $urandom_range(1, 32'h00C0_0000);
      end else if (kind < 50) begin
        base  = $urandom;
        len_b = 32'd0;
      end else if (kind < 85) begin
        base  = $urandom;
        len_b = $urandom >> $urandom_range(8, 31);
      end else begin
        base  = $urandom;
        len_b = $urandom >> $urandom_range(0, 7);
      end
      add_region(base, len_b);
    end
    total_regions = pending_regions.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_regions.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (64) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("missing results", expected_results.size(), 0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
